@@ hdl/lse_pkg.sv @@
// Package for the LSB steganography stream extractor.
// Holds the beat and configuration types, the phase and kind codes and the sizing constants.
// No dependencies.
package lse_pkg;

  // Width of the extension length and payload length fields of the hidden record.
  localparam int LENGTH_BITS = 32;
  localparam int MAGIC_BITS  = 16;
  localparam int BYTE_BITS   = 8;

  // The bit accumulator must hold the magic word as well as a length field.
  localparam int SHIFT_W = (LENGTH_BITS > MAGIC_BITS) ? LENGTH_BITS : MAGIC_BITS;
  localparam int CNT_W   = $clog2(SHIFT_W);
  localparam int CNT_N_W = CNT_W + 1;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MAGIC_WORD  = 1'b0,
    CFG_HEADER_SKIP = 1'b1
  } lse_cfg_index_e;

  typedef enum logic [2:0] {
    KIND_EXT        = 3'd0,
    KIND_PAY        = 3'd1,
    KIND_MAGIC_ERR  = 3'd2,
    KIND_EXTLEN_ERR = 3'd3,
    KIND_DONE       = 3'd4
  } lse_kind_e;

  typedef enum logic [6:0] {
    PH_SKIP   = 7'b0000001,
    PH_MAGIC  = 7'b0000010,
    PH_EXTLEN = 7'b0000100,
    PH_EXT    = 7'b0001000,
    PH_PLEN   = 7'b0010000,
    PH_PAY    = 7'b0100000,
    PH_HALT   = 7'b1000000
  } lse_phase_e;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] pixel_byte;
  } lse_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    lse_kind_e  kind;
    logic       last;
  } lse_out_t;

  typedef struct packed {
    logic [MAGIC_BITS-1:0] magic_word;
    logic [7:0]            header_skip;
  } lse_cfg_t;

endpackage

@@ hdl/lse_core.sv @@
// Record parser of the LSB steganography stream extractor.
// Holds the framing state and turns one accepted image byte into at most one result.
// Depends on lse_pkg.
module lse_core import lse_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  lse_in_t  item_i,
  input  lse_cfg_t cfg_i,
  output logic     res_valid_o,
  output lse_out_t res_o
);

  lse_phase_e             phase_q, phase_d;
  logic [7:0]             byte_count_q, byte_count_d;
  logic [CNT_W-1:0]       bit_count_q, bit_count_d;
  logic [SHIFT_W-1:0]     bit_shift_q, bit_shift_d;
  logic [2:0]             ext_remaining_q, ext_remaining_d;
  logic [LENGTH_BITS-1:0] payload_remaining_q, payload_remaining_d;
  logic [CNT_N_W-1:0]     n;
  logic [LENGTH_BITS-1:0] len_v;

  always_comb begin
    phase_d             = phase_q;
    byte_count_d        = byte_count_q;
    bit_count_d         = bit_count_q;
    bit_shift_d         = bit_shift_q;
    ext_remaining_d     = ext_remaining_q;
    payload_remaining_d = payload_remaining_q;
    res_valid_o         = 1'b0;
    res_o.out_byte      = '0;
    res_o.kind          = KIND_EXT;
    res_o.last          = 1'b0;
    n                   = '0;
    len_v               = '0;

    if (item_i.frame_start) begin
      phase_d             = PH_SKIP;
      byte_count_d        = '0;
      bit_count_d         = '0;
      bit_shift_d         = '0;
      ext_remaining_d     = '0;
      payload_remaining_d = '0;
    end

    if (phase_d == PH_SKIP) begin
      if (byte_count_d < cfg_i.header_skip) begin
        byte_count_d = byte_count_d + 8'd1;
      end else begin
        phase_d     = PH_MAGIC;
        bit_count_d = '0;
        bit_shift_d = '0;
      end
    end

    // Only the magic through payload phases consume a hidden bit.
    if (phase_d != PH_SKIP && phase_d != PH_HALT) begin
      bit_shift_d = {bit_shift_d[SHIFT_W-2:0], item_i.pixel_byte[0]};
      n           = {1'b0, bit_count_d} + CNT_N_W'(1);
      len_v       = bit_shift_d[LENGTH_BITS-1:0];
      unique case (phase_d)
        PH_MAGIC: begin
          if (n < CNT_N_W'(MAGIC_BITS)) begin
            bit_count_d = n[CNT_W-1:0];
          end else begin
            bit_count_d = '0;
            if (bit_shift_d[MAGIC_BITS-1:0] != cfg_i.magic_word) begin
              phase_d     = PH_HALT;
              res_valid_o = 1'b1;
              res_o.kind  = KIND_MAGIC_ERR;
              res_o.last  = 1'b1;
            end else begin
              phase_d = PH_EXTLEN;
            end
            bit_shift_d = '0;
          end
        end
        PH_EXTLEN: begin
          if (n < CNT_N_W'(LENGTH_BITS)) begin
            bit_count_d = n[CNT_W-1:0];
          end else begin
            bit_count_d = '0;
            bit_shift_d = '0;
            if (len_v < LENGTH_BITS'(2) || len_v > LENGTH_BITS'(4)) begin
              phase_d     = PH_HALT;
              res_valid_o = 1'b1;
              res_o.kind  = KIND_EXTLEN_ERR;
              res_o.last  = 1'b1;
            end else begin
              ext_remaining_d = len_v[2:0];
              phase_d         = PH_EXT;
            end
          end
        end
        PH_EXT: begin
          if (n < CNT_N_W'(BYTE_BITS)) begin
            bit_count_d = n[CNT_W-1:0];
          end else begin
            bit_count_d     = '0;
            res_valid_o     = 1'b1;
            res_o.out_byte  = bit_shift_d[7:0];
            res_o.kind      = KIND_EXT;
            bit_shift_d     = '0;
            ext_remaining_d = ext_remaining_d - 3'd1;
            if (ext_remaining_d == 3'd0) begin
              phase_d = PH_PLEN;
            end
          end
        end
        PH_PLEN: begin
          if (n < CNT_N_W'(LENGTH_BITS)) begin
            bit_count_d = n[CNT_W-1:0];
          end else begin
            bit_count_d = '0;
            bit_shift_d = '0;
            // A zero length or one with the top bit set means no payload.
            if (len_v == '0 || len_v[LENGTH_BITS-1]) begin
              phase_d     = PH_HALT;
              res_valid_o = 1'b1;
              res_o.kind  = KIND_DONE;
              res_o.last  = 1'b1;
            end else begin
              payload_remaining_d = len_v;
              phase_d             = PH_PAY;
            end
          end
        end
        PH_PAY: begin
          if (n < CNT_N_W'(BYTE_BITS)) begin
            bit_count_d = n[CNT_W-1:0];
          end else begin
            bit_count_d         = '0;
            res_valid_o         = 1'b1;
            res_o.out_byte      = bit_shift_d[7:0];
            res_o.kind          = KIND_PAY;
            bit_shift_d         = '0;
            payload_remaining_d = payload_remaining_d - LENGTH_BITS'(1);
            if (payload_remaining_d == '0) begin
              phase_d    = PH_HALT;
              res_o.last = 1'b1;
            end
          end
        end
        default: begin
          phase_d = PH_HALT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q             <= PH_SKIP;
      byte_count_q        <= '0;
      bit_count_q         <= '0;
      bit_shift_q         <= '0;
      ext_remaining_q     <= '0;
      payload_remaining_q <= '0;
    end else if (accept_i) begin
      phase_q             <= phase_d;
      byte_count_q        <= byte_count_d;
      bit_count_q         <= bit_count_d;
      bit_shift_q         <= bit_shift_d;
      ext_remaining_q     <= ext_remaining_d;
      payload_remaining_q <= payload_remaining_d;
    end
  end

endmodule

@@ hdl/lse_out_reg.sv @@
// Result register of the LSB steganography stream extractor.
// Holds one result beat toward the downstream side and reports when it can take another.
// Depends on lse_pkg.
module lse_out_reg import lse_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  logic     res_valid_i,
  input  lse_out_t res_i,
  output logic     free_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output lse_out_t out_item_o
);

  logic     valid_q;
  lse_out_t data_q;

  // The register can be refilled when it is empty or its beat leaves this cycle.
  assign free_o      = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i && res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i && res_valid_i) begin
      data_q <= res_i;
    end
  end

endmodule

@@ hdl/lsb_stego_stream_extractor.sv @@
// Top level of the LSB steganography stream extractor.
// Holds the configuration registers and connects the record parser to the result register.
// Depends on lse_pkg, lse_core and lse_out_reg.
//
//   Channel   Direction  Handshake                  Beat contents
//   in        input      in_valid_i / in_stall_o    frame_start, pixel_byte
//   out       output     out_valid_o / out_stall_i  out_byte, kind, last
//   cfg       input      cfg_we_i                   cfg_index_i, cfg_data_i
//
// One image byte is taken in every cycle that the input does not stall. A byte that
// completes an extension byte, a payload byte, an error or the empty-payload case puts
// its result on the output in the cycle after acceptance, via the single result register.
// The input stalls only while that register holds a result that downstream stalls.
// Reset clears the framing state and returns the configuration to a zero magic word
// and a header skip of 54 bytes; a stream without a frame start is parsed as a frame.
module lsb_stego_stream_extractor import lse_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  lse_in_t                in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output lse_out_t               out_item_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  lse_cfg_t cfg_q;
  logic     accept;
  logic     free;
  logic     res_valid;
  lse_out_t res;

  // Configuration writes land directly; the register index selects one of the two fields.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic_word  <= '0;
      cfg_q.header_skip <= 8'd54;
    end else if (cfg_we_i) begin
      unique case (lse_cfg_index_e'(cfg_index_i))
        CFG_MAGIC_WORD:  cfg_q.magic_word  <= cfg_data_i[MAGIC_BITS-1:0];
        CFG_HEADER_SKIP: cfg_q.header_skip <= cfg_data_i[7:0];
        default:         cfg_q             <= cfg_q;
      endcase
    end
  end

  // A byte is accepted whenever the result register has room for what it may produce.
  assign in_stall_o = !free;
  assign accept     = in_valid_i && free;

  lse_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  lse_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .res_valid_i (res_valid),
    .res_i       (res),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
